### rtl/ffba_pkg.sv
// Shared types, constants and codes of the first-fit block allocator.
package ffba_pkg;

    localparam int NCELL        = 64;
    localparam int GRP          = 8;
    localparam int NGRP         = NCELL / GRP;
    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 8;
    localparam int PAGE_SHIFT   = 12;
    localparam int MAX_PAGES    = 16;
    localparam logic [16:0] RESET_REGION = 17'd4096;
    localparam logic [15:0] RESET_SIZE   = 16'(RESET_REGION - 17'(HEADER_BYTES));

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    // The last request code is served as a query.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_SIZE = 2'd1,
        STS_NO_FIT   = 2'd2,
        STS_BAD_ADDR = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_FIT,
        OP_ADDR,
        OP_SELECT,
        OP_SPLIT,
        OP_TAKE,
        OP_RELEASE,
        OP_MERGE_PREV
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PREFIX,
        ST_SELECT,
        ST_GATHER,
        ST_APPLY,
        ST_MERGE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] off;
        logic [15:0] size;
        logic        busy;
        logic        used;
    } t_ent;

    typedef struct packed {
        t_ent ent;
        logic hit;
        logic first;
    } t_cell_st;

    typedef struct packed {
        t_op         op;
        logic [16:0] val;
        logic        merge_next;
    } t_cmd;

endpackage

### rtl/ffba_if.sv
// Valid/ready channel interfaces for requests and responses.
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] req_size;
    logic [15:0] req_addr;
    modport source (output valid, req_type, req_size, req_addr, input ready);
    modport sink   (input valid, req_type, req_size, req_addr, output ready);
endinterface

interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] addr;
    logic [16:0] available;
    modport source (output valid, status, addr, available, input ready);
    modport sink   (input valid, status, addr, available, output ready);
endinterface

### rtl/ffba_cell.sv
// One table entry of the allocator chain with its neighbor handoff logic.
module ffba_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head,
    input  ffba_pkg::t_cmd    i_cmd,
    input  logic              i_earlier,
    input  ffba_pkg::t_cell_st i_left,
    input  ffba_pkg::t_cell_st i_right,
    output ffba_pkg::t_cell_st o_st
);

    ffba_pkg::t_ent r_ent, n_ent;
    logic r_hit, n_hit, r_first, n_first, r_past, n_past;
    logic fit, ahit;

    assign fit  = r_ent.used && !r_ent.busy && ({1'b0, r_ent.size} >= i_cmd.val);
    assign ahit = r_ent.used &&
                  (({1'b0, r_ent.off} + 17'(ffba_pkg::HEADER_BYTES)) == i_cmd.val);

    always_comb begin
        n_ent   = r_ent;
        n_hit   = r_hit;
        n_first = r_first;
        n_past  = r_past;
        case (i_cmd.op)
            ffba_pkg::OP_INIT: begin
                n_ent.off  = '0;
                n_ent.size = i_cmd.val[15:0];
                n_ent.busy = 1'b0;
                n_ent.used = i_head;
            end
            ffba_pkg::OP_FIT:    n_hit = fit;
            ffba_pkg::OP_ADDR:   n_hit = ahit;
            ffba_pkg::OP_SELECT: begin
                n_first = r_hit && !i_earlier;
                n_past  = i_earlier;
            end
            ffba_pkg::OP_SPLIT: begin
                if (r_first) begin
                    n_ent.size = i_cmd.val[15:0];
                    n_ent.busy = 1'b1;
                end else if (i_left.first) begin
                    // The remainder of the split block lands in this cell.
                    n_ent.off  = i_left.ent.off + 16'(ffba_pkg::HEADER_BYTES)
                                 + i_cmd.val[15:0];
                    n_ent.size = i_left.ent.size - i_cmd.val[15:0]
                                 - 16'(ffba_pkg::HEADER_BYTES);
                    n_ent.busy = 1'b0;
                    n_ent.used = 1'b1;
                end else if (r_past) begin
                    n_ent = i_left.ent;
                end
            end
            ffba_pkg::OP_TAKE: begin
                if (r_first) n_ent.busy = 1'b1;
            end
            ffba_pkg::OP_RELEASE: begin
                if (r_first) begin
                    n_ent.busy = 1'b0;
                    if (i_cmd.merge_next) begin
                        n_ent.size = r_ent.size + i_right.ent.size
                                     + 16'(ffba_pkg::HEADER_BYTES);
                    end
                end else if (r_past && i_cmd.merge_next) begin
                    n_ent = i_right.ent;
                end
            end
            ffba_pkg::OP_MERGE_PREV: begin
                if (i_right.first) begin
                    n_ent.size = r_ent.size + i_right.ent.size
                                 + 16'(ffba_pkg::HEADER_BYTES);
                end else if (r_first || r_past) begin
                    n_ent = i_right.ent;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.off  <= '0;
            r_ent.size <= ffba_pkg::RESET_SIZE;
            r_ent.busy <= 1'b0;
            r_ent.used <= i_head;
            r_hit      <= 1'b0;
            r_first    <= 1'b0;
            r_past     <= 1'b0;
        end else begin
            r_ent   <= n_ent;
            r_hit   <= n_hit;
            r_first <= n_first;
            r_past  <= n_past;
        end
    end

    assign o_st.ent   = r_ent;
    assign o_st.hit   = r_hit;
    assign o_st.first = r_first;

endmodule

### rtl/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator: sequencer, gather logic and cell chain.
//
// Requests arrive on i_req (alloc, free or query) and each produces exactly one
// beat on o_rsp carrying status, granted payload offset and the free byte count
// after the request. The block table lives in a chain of 64 cells, one entry
// each; splits shift the entries above the split point one cell up and merges
// shift them down, each through neighbor handoff.
// A request passes from accept to response valid through match, a registered
// two-level first-hit prefix, selection, gather of the chosen entry, apply, a
// second merge for a free that merges with its lower neighbor, and the load of
// the response register. One request is in flight at a time; the next beat is
// accepted in the cycle after the response is loaded at the earliest, so the
// block takes no new request before it has loaded the response of the last.
// i_cfg_we writes region_bytes only while the sequencer is idle; the table is rebuilt in that
// cycle as one free block over the page-rounded region. Reset gives a 4096-byte region.
// If the receiver stalls, the response register holds the beat and the
// sequencer waits in its final state until the register can be reloaded.
module first_fit_block_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffba_req_if.sink    i_req,
    ffba_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_region_bytes
);

    localparam int N = ffba_pkg::NCELL;

    ffba_pkg::t_state r_state, n_state;
    ffba_pkg::t_cmd   cmd;
    ffba_pkg::t_cell_st st [N];
    ffba_pkg::t_cell_st lft [N];
    ffba_pkg::t_cell_st rgt [N];
    logic [N-1:0] earlier;
    logic [N-1:0] hits;

    logic [1:0]  r_type;
    logic [15:0] r_size;
    logic [15:0] r_addr;
    logic [16:0] r_rs;
    logic [ffba_pkg::NGRP-1:0] r_grp;
    logic [15:0] r_sel_size;
    logic        r_split, r_pf;
    logic        r_nf;
    ffba_pkg::t_status r_status;
    logic [15:0] r_res_addr;
    logic [16:0] r_avail;
    logic        r_ovalid;
    ffba_pkg::t_status r_o_status;
    logic [15:0] r_o_addr;
    logic [16:0] r_o_avail;

    // Gathered view of the selected entry.
    logic        found, sel_busy, nf, pf;
    logic [15:0] sel_off, sel_size;
    logic        out_free;

    // Region size rounding for configuration writes.
    logic [16:0] cfg_req;
    logic [17:0] cfg_up;
    logic [5:0]  cfg_pages;
    logic [4:0]  cfg_pages_sat;
    logic [16:0] cfg_total;

    assign cfg_req       = (i_cfg_region_bytes == 17'd0) ? 17'd1 : i_cfg_region_bytes;
    assign cfg_up        = {1'b0, cfg_req} + 18'((1 << ffba_pkg::PAGE_SHIFT) - 1);
    assign cfg_pages     = cfg_up[17:ffba_pkg::PAGE_SHIFT];
    assign cfg_pages_sat = (cfg_pages > 6'(ffba_pkg::MAX_PAGES)) ?
                           5'(ffba_pkg::MAX_PAGES) : cfg_pages[4:0];
    assign cfg_total     = {cfg_pages_sat, {ffba_pkg::PAGE_SHIFT{1'b0}}};

    // Cell chain.
    for (genvar i = 0; i < N; i++) begin : g_cell
        localparam int G = i / ffba_pkg::GRP;
        localparam int K = i % ffba_pkg::GRP;
        localparam logic [ffba_pkg::NGRP-1:0] GMASK = ffba_pkg::NGRP'((1 << G) - 1);
        localparam logic [ffba_pkg::GRP-1:0]  KMASK = ffba_pkg::GRP'((1 << K) - 1);

        if (i == 0) begin : g_l0
            assign lft[i] = '0;
        end else begin : g_ln
            assign lft[i] = st[i-1];
        end
        if (i == N - 1) begin : g_rl
            assign rgt[i] = '0;
        end else begin : g_rn
            assign rgt[i] = st[i+1];
        end

        assign hits[i]    = st[i].hit;
        // A hit in an earlier group or earlier in this cell's own group.
        assign earlier[i] = (|(r_grp & GMASK)) |
                            (|(hits[G*ffba_pkg::GRP +: ffba_pkg::GRP] & KMASK));

        ffba_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_head    (i == 0),
            .i_cmd     (cmd),
            .i_earlier (earlier[i]),
            .i_left    (lft[i]),
            .i_right   (rgt[i]),
            .o_st      (st[i])
        );
    end

    // AND-OR gather of the one selected cell and its neighbors.
    always_comb begin
        found    = 1'b0;
        sel_busy = 1'b0;
        nf       = 1'b0;
        pf       = 1'b0;
        sel_off  = '0;
        sel_size = '0;
        for (int i = 0; i < N; i++) begin
            found    |= st[i].first;
            sel_busy |= st[i].first & st[i].ent.busy;
            sel_off  |= {16{st[i].first}} & st[i].ent.off;
            sel_size |= {16{st[i].first}} & st[i].ent.size;
            nf |= st[i].first & rgt[i].ent.used & !rgt[i].ent.busy;
            pf |= st[i].first & lft[i].ent.used & !lft[i].ent.busy;
        end
    end

    assign out_free = !r_ovalid || o_rsp.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffba_pkg::ST_IDLE:   if (i_req.valid) n_state = ffba_pkg::ST_MATCH;
            ffba_pkg::ST_MATCH:  n_state = ffba_pkg::ST_PREFIX;
            ffba_pkg::ST_PREFIX: n_state = ffba_pkg::ST_SELECT;
            ffba_pkg::ST_SELECT: n_state = ffba_pkg::ST_GATHER;
            ffba_pkg::ST_GATHER: n_state = ffba_pkg::ST_APPLY;
            ffba_pkg::ST_APPLY: begin
                if (r_status == ffba_pkg::STS_OK && r_type == ffba_pkg::REQ_FREE && r_pf)
                    n_state = ffba_pkg::ST_MERGE;
                else
                    n_state = ffba_pkg::ST_DONE;
            end
            ffba_pkg::ST_MERGE:  n_state = ffba_pkg::ST_DONE;
            ffba_pkg::ST_DONE:   if (out_free) n_state = ffba_pkg::ST_IDLE;
            default:             n_state = ffba_pkg::ST_IDLE;
        endcase
    end

    // Commands broadcast to the chain.
    always_comb begin
        cmd.op         = ffba_pkg::OP_NONE;
        cmd.val        = '0;
        cmd.merge_next = 1'b0;
        case (r_state)
            ffba_pkg::ST_IDLE: begin
                if (i_cfg_we) begin
                    cmd.op  = ffba_pkg::OP_INIT;
                    cmd.val = cfg_total - 17'(ffba_pkg::HEADER_BYTES);
                end
            end
            ffba_pkg::ST_MATCH: begin
                if (r_type == ffba_pkg::REQ_FREE) begin
                    cmd.op  = ffba_pkg::OP_ADDR;
                    cmd.val = {1'b0, r_addr};
                end else begin
                    cmd.op  = ffba_pkg::OP_FIT;
                    cmd.val = r_rs;
                end
            end
            ffba_pkg::ST_SELECT: cmd.op = ffba_pkg::OP_SELECT;
            ffba_pkg::ST_APPLY: begin
                if (r_status == ffba_pkg::STS_OK) begin
                    if (r_type == ffba_pkg::REQ_ALLOC) begin
                        cmd.op  = r_split ? ffba_pkg::OP_SPLIT : ffba_pkg::OP_TAKE;
                        cmd.val = r_rs;
                    end else if (r_type == ffba_pkg::REQ_FREE) begin
                        cmd.op         = ffba_pkg::OP_RELEASE;
                        cmd.merge_next = r_nf;
                    end
                end
            end
            ffba_pkg::ST_MERGE: cmd.op = ffba_pkg::OP_MERGE_PREV;
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffba_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_avail  <= ffba_pkg::RESET_REGION;
        end else begin
            r_state <= n_state;
            if (r_state == ffba_pkg::ST_IDLE && i_cfg_we)
                r_avail <= cfg_total;
            if (r_state == ffba_pkg::ST_APPLY && r_status == ffba_pkg::STS_OK) begin
                if (r_type == ffba_pkg::REQ_ALLOC)
                    r_avail <= r_avail - (r_split ? r_rs : {1'b0, r_sel_size})
                               - 17'(ffba_pkg::HEADER_BYTES);
                else if (r_type == ffba_pkg::REQ_FREE)
                    r_avail <= r_avail + {1'b0, r_sel_size}
                               + 17'(ffba_pkg::HEADER_BYTES);
            end
            if (r_state == ffba_pkg::ST_DONE && out_free)
                r_ovalid <= 1'b1;
            else if (o_rsp.ready)
                r_ovalid <= 1'b0;
        end
    end

    // Request, gather and response payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ffba_pkg::ST_IDLE && i_req.valid) begin
            r_type <= i_req.req_type;
            r_size <= i_req.req_size;
            r_addr <= i_req.req_addr;
            r_rs   <= ({1'b0, i_req.req_size} + 17'(ffba_pkg::ALIGN_BYTES - 1))
                      & ~17'(ffba_pkg::ALIGN_BYTES - 1);
        end
        if (r_state == ffba_pkg::ST_PREFIX) begin
            for (int g = 0; g < ffba_pkg::NGRP; g++)
                r_grp[g] <= |hits[g*ffba_pkg::GRP +: ffba_pkg::GRP];
        end
        if (r_state == ffba_pkg::ST_GATHER) begin
            r_sel_size <= sel_size;
            r_nf       <= nf;
            r_pf       <= pf;
            r_split    <= ((r_rs + 17'(ffba_pkg::HEADER_BYTES)) < {1'b0, sel_size}) &&
                          !st[N-1].ent.used;
            r_res_addr <= '0;
            r_status   <= ffba_pkg::STS_OK;
            if (r_type == ffba_pkg::REQ_ALLOC) begin
                if (r_size == 16'd0) begin
                    r_status <= ffba_pkg::STS_BAD_SIZE;
                end else if (!found) begin
                    r_status <= ffba_pkg::STS_NO_FIT;
                end else begin
                    r_res_addr <= sel_off + 16'(ffba_pkg::HEADER_BYTES);
                end
            end else if (r_type == ffba_pkg::REQ_FREE) begin
                if (!found || !sel_busy)
                    r_status <= ffba_pkg::STS_BAD_ADDR;
            end
        end
        if (r_state == ffba_pkg::ST_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_addr   <= r_res_addr;
            r_o_avail  <= r_avail;
        end
    end

    assign i_req.ready     = (r_state == ffba_pkg::ST_IDLE);
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.addr      = r_o_addr;
    assign o_rsp.available = r_o_avail;

endmodule

### rtl/ffba_checker.sv
// Port-level checker for the allocator, bound to the top level.
module ffba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [15:0] i_rsp_addr,
    input logic [16:0] i_rsp_available
);

    // A held response beat keeps its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_addr)
             && $stable(i_rsp_available)))
        else $error("response changed while stalled");

    // Reset leaves no response pending.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // Failed requests never grant an address.
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ffba_pkg::STS_OK) |-> (i_rsp_addr == 16'd0))
        else $error("address granted on a failed request");

    // After a request beat the block is busy working on it.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in flight");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_addr      (o_rsp.addr),
    .i_rsp_available (o_rsp.available)
);

### bench/ffba_checker.sv
// Checker for the first-fit block allocator: predicts each response beat and compares it.
module ffba_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffba_req_if.sink    i_req_mon,
    ffba_rsp_if.sink    i_rsp_mon,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_region_bytes,
    output int          o_fail_count,
    output int          o_pending_count
);

    typedef struct {
        int unsigned off;
        int unsigned size;
        bit          busy;
    } t_blk;

    typedef struct {
        ffba_pkg::t_status status;
        logic [15:0]       addr;
        logic [16:0]       available;
    } t_reply;

    t_blk        blocks[ffba_pkg::NCELL];
    int unsigned nblocks;
    t_reply      replies_due[$];
    int          fails;

    assign o_fail_count    = fails;
    assign o_pending_count = replies_due.size();

    function automatic void rebuild(input logic [16:0] req);
        int unsigned r;
        int unsigned total;
        r = (req == 0) ? 1 : req;
        total = ((r + 4095) / 4096) * 4096;
        if (total > 65536)
            total = 65536;
        nblocks = 0;
        if (total >= ffba_pkg::HEADER_BYTES) begin
            blocks[0] = '{0, total - ffba_pkg::HEADER_BYTES, 1'b0};
            nblocks = 1;
        end
    endfunction

    function automatic int unsigned free_total();
        int unsigned s;
        s = 0;
        for (int i = 0; i < nblocks; i++)
            if (!blocks[i].busy)
                s += blocks[i].size + ffba_pkg::HEADER_BYTES;
        return s;
    endfunction

    function automatic void absorb_next(input int i);
        blocks[i].size += blocks[i + 1].size + ffba_pkg::HEADER_BYTES;
        for (int j = i + 1; j + 1 < nblocks; j++)
            blocks[j] = blocks[j + 1];
        nblocks--;
    endfunction

    function automatic t_reply serve(input logic [1:0] kind, input logic [15:0] sz,
                                     input logic [15:0] a);
        t_reply      rep;
        int unsigned want;
        int          k;
        rep.status = ffba_pkg::STS_OK;
        rep.addr   = '0;
        if (kind == ffba_pkg::REQ_ALLOC) begin
            if (sz == 0) begin
                rep.status = ffba_pkg::STS_BAD_SIZE;
            end else begin
                want = ((sz + ffba_pkg::ALIGN_BYTES - 1) / ffba_pkg::ALIGN_BYTES)
                       * ffba_pkg::ALIGN_BYTES;
                rep.status = ffba_pkg::STS_NO_FIT;
                for (int i = 0; i < nblocks; i++) begin
                    if (!blocks[i].busy && want <= blocks[i].size) begin
                        if (want + ffba_pkg::HEADER_BYTES < blocks[i].size &&
                            nblocks < ffba_pkg::NCELL) begin
                            for (int j = nblocks; j > i + 1; j--)
                                blocks[j] = blocks[j - 1];
                            blocks[i + 1] = '{blocks[i].off + ffba_pkg::HEADER_BYTES + want,
                                              blocks[i].size - want - ffba_pkg::HEADER_BYTES,
                                              1'b0};
                            nblocks++;
                            blocks[i].size = want;
                        end
                        blocks[i].busy = 1'b1;
                        rep.status = ffba_pkg::STS_OK;
                        rep.addr = 16'(blocks[i].off + ffba_pkg::HEADER_BYTES);
                        break;
                    end
                end
            end
        end else if (kind == ffba_pkg::REQ_FREE) begin
            k = -1;
            for (int i = 0; i < nblocks; i++)
                if (k < 0 && blocks[i].off + ffba_pkg::HEADER_BYTES == a)
                    k = i;
            if (k < 0 || !blocks[k].busy) begin
                rep.status = ffba_pkg::STS_BAD_ADDR;
            end else begin
                blocks[k].busy = 1'b0;
                if (k + 1 < nblocks && !blocks[k + 1].busy)
                    absorb_next(k);
                if (k > 0 && !blocks[k - 1].busy)
                    absorb_next(k - 1);
            end
        end
        rep.available = 17'(free_total());
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            rebuild(ffba_pkg::RESET_REGION);
            replies_due.delete();
            fails <= 0;
        end else begin
            if (i_cfg_we)
                rebuild(i_cfg_region_bytes);
            if (i_req_mon.valid && i_req_mon.ready)
                replies_due.push_back(serve(i_req_mon.req_type, i_req_mon.req_size,
                                            i_req_mon.req_addr));
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: response beat with nothing expected", $time);
                    fails <= fails + 1;
                end else begin
                    want = replies_due.pop_front();
                    if (i_rsp_mon.status !== want.status || i_rsp_mon.addr !== want.addr ||
                        i_rsp_mon.available !== want.available) begin
                        $display("%0t: expected status %0d addr %0d avail %0d, got %0d %0d %0d",
                                 $time, want.status, want.addr, want.available,
                                 i_rsp_mon.status, i_rsp_mon.addr, i_rsp_mon.available);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

### bench/tb.sv
// Testbench top for the first-fit block allocator: stimulus, region settings and verdict.
module tb;

    localparam int QUIET_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [16:0] cfg_region;
    int          fail_count;
    int          pending_count;
    int          quiet_cycles;

    // Payload offsets handed out by the block and still held, so that frees can
    // mostly target real grants.
    logic [15:0] held_grants[$];
    bit          req_gaps_on;
    bit          rsp_stalls_on;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_block_allocator_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req             (req_ch),
        .o_rsp             (rsp_ch),
        .i_cfg_we          (cfg_we),
        .i_cfg_region_bytes(cfg_region)
    );

    ffba_scoreboard u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_mon         (req_ch),
        .i_rsp_mon         (rsp_ch),
        .i_cfg_we          (cfg_we),
        .i_cfg_region_bytes(cfg_region),
        .o_fail_count      (fail_count),
        .o_pending_count   (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    endfunction

    // The receiver stalls at random; a new stall is drawn after each ready cycle.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_stalls_on)
                stall_left = gap_len();
        end
    end

    // Remember granted offsets as the response beats go by.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ffba_pkg::STS_OK &&
            rsp_ch.addr != 0)
            held_grants.push_back(rsp_ch.addr);
    end

    // Watchdog: any accepted beat on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sends one request beat and holds it until accepted. The previous beat was
    // dropped at the edge that took it, so this one never starts at that edge;
    // a gap may delay it more.
    task automatic send_beat(input logic [1:0] kind, input logic [15:0] sz,
                             input logic [15:0] a);
        int idle;
        idle = req_gaps_on ? gap_len() : 0;
        repeat (idle + 1) @(posedge i_clk);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.req_size <= sz;
        req_ch.req_addr <= a;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= 2'($urandom);
        req_ch.req_size <= 16'($urandom);
        req_ch.req_addr <= 16'($urandom);
    endtask

    // Waits until every response has come back, lets the block settle, then
    // writes a new region. The held grants are dropped along with the table.
    task automatic set_region(input logic [16:0] bytes);
        while (pending_count != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        cfg_we     <= 1'b1;
        cfg_region <= bytes;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        held_grants.delete();
    endtask

    // Random allocation sizes, mostly small so that the table fills and
    // fragments, with the odd huge one.
    function automatic logic [15:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 4));
            2, 3:    return 16'($urandom_range(200, 2000));
            default: return 16'($urandom_range(1, 120));
        endcase
    endfunction

    task automatic random_beat();
        int          pick;
        int          idx;
        logic [15:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            send_beat(ffba_pkg::REQ_ALLOC, rand_size(), 16'($urandom));
        end else if (pick < 88 && held_grants.size() != 0) begin
            idx = $urandom_range(0, held_grants.size() - 1);
            a = held_grants[idx];
            held_grants.delete(idx);
            send_beat(ffba_pkg::REQ_FREE, 16'($urandom), a);
        end else if (pick < 94) begin
            // Broken free: a random address, or an aligned guess near a header.
            a = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8191) & ~16'd7);
            send_beat(ffba_pkg::REQ_FREE, 16'($urandom), a);
        end else begin
            send_beat($urandom_range(0, 1) ? ffba_pkg::REQ_QUERY : ffba_pkg::REQ_SPARE,
                      16'($urandom), 16'($urandom));
        end
    endtask

    logic [16:0] region_plan[6];

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_region      = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.req_size = '0;
        req_ch.req_addr = '0;
        req_gaps_on     = 1'b0;
        rsp_stalls_on   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset region: size extremes, rounding, every
        // request type, a split, a merge with the following block and frees that miss.
        send_beat(ffba_pkg::REQ_QUERY, 16'd0, 16'd0);
        send_beat(ffba_pkg::REQ_ALLOC, 16'd0, 16'd0);
        send_beat(ffba_pkg::REQ_ALLOC, 16'hFFFF, 16'hFFFF);
        send_beat(ffba_pkg::REQ_ALLOC, 16'd1, 16'd0);
        send_beat(ffba_pkg::REQ_ALLOC, 16'd9, 16'd0);
        send_beat(ffba_pkg::REQ_ALLOC, 16'd24, 16'd0);
        send_beat(ffba_pkg::REQ_FREE, 16'd0, 16'd40);
        send_beat(ffba_pkg::REQ_FREE, 16'd0, 16'd40);
        send_beat(ffba_pkg::REQ_FREE, 16'd0, 16'd16);
        send_beat(ffba_pkg::REQ_FREE, 16'd0, 16'd64);
        send_beat(ffba_pkg::REQ_FREE, 16'hFFFF, 16'hFFFF);
        send_beat(ffba_pkg::REQ_SPARE, 16'hFFFF, 16'hFFFF);
        send_beat(ffba_pkg::REQ_ALLOC, 16'd4080, 16'd0);
        send_beat(ffba_pkg::REQ_FREE, 16'd0, 16'd16);
        send_beat(ffba_pkg::REQ_ALLOC, 16'd4064, 16'd0);
        send_beat(ffba_pkg::REQ_FREE, 16'd0, 16'd16);

        // Zero region becomes one page; the largest request saturates.
        set_region(17'd0);
        send_beat(ffba_pkg::REQ_ALLOC, 16'd4072, 16'd0);
        set_region(17'h1FFFF);
        send_beat(ffba_pkg::REQ_ALLOC, 16'hFFFF, 16'd0);
        send_beat(ffba_pkg::REQ_ALLOC, 16'd65512, 16'd0);
        send_beat(ffba_pkg::REQ_QUERY, 16'd0, 16'd0);
        held_grants.delete();

        // Fill the table with small grants so splitting is refused at the end.
        set_region(17'd65536);
        for (int i = 0; i < 70; i++)
            send_beat(ffba_pkg::REQ_ALLOC, 16'd8, 16'd0);

        region_plan = '{17'd4096, 17'd1, 17'd65536, 17'd10000, 17'd70000, 17'd8192};
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        for (int p = 0; p < 6; p++) begin
            set_region(region_plan[p]);
            // Phase 2 runs without request gaps and phase 3 without response stalls.
            req_gaps_on   = (p != 2);
            rsp_stalls_on = (p != 3);
            for (int n = 0; n < 250; n++)
                random_beat();
        end

        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
